FILE: rtl/simon_pkg.sv
// Shared types and constants for the Simon 128/128 cipher block.
package simon_pkg;

	localparam int KEY_W           = 64;
	localparam int ROUND_COUNT_DEF = 68;
	localparam int CFG_IDX_W       = 2;
	localparam int Z2_LEN          = 62;

	// z2 bit sequence, first element in the top bit
	localparam logic [Z2_LEN-1:0] Z2_SEQ = 62'h2BDC0D262847E5B3;
	localparam logic [KEY_W-1:0]  ROUND_CONST = 64'hFFFF_FFFF_FFFF_FFFC;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 2'd1;

	// request selector
	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] block_word_first;
		logic [KEY_W-1:0] block_word_second;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] result_word_first;
		logic [KEY_W-1:0] result_word_second;
	} out_item_t;

	// key ring control: fill pushes at the tail, fwd/bwd rotate
	typedef struct packed {
		logic fill;
		logic fwd;
		logic bwd;
	} ring_ctl_t;

endpackage

FILE: rtl/simon_128_128_block_cipher_top.sv
// Top level of the Simon 128/128 block cipher: key registers, key ring, round engine.
//
// Usage notes:
// - Input channel (in_valid/in_stall/in_data): one transfer carries the selector
//   (0 encrypt, 1 decrypt) and a 128-bit block as two 64-bit words.
// - Output channel (out_valid/out_stall/out_data): one transfer per input item,
//   in order. out_data holds while out_stall is high.
// - Config port (cfg_we/cfg_index/cfg_wdata): index 0 is the first key word,
//   index 1 the second; other indexes are ignored. Write only while idle.
// - Every key write (and reset, with the zero key) starts a key expansion:
//   the start is latched, then the generator pushes ROUND_COUNT round keys into the ring.
//   in_stall stays high until it is done.
// - Rounds: one Feistel round per cycle, ROUND_COUNT rounds per item. The round key ring
//   rotates one cell per round and returns to its start position after an item.
// - Only one item is in its rounds at a time, in the single shared round unit;
//   a new item is accepted while the previous result waits.
// - If the receiver stalls while a finished result is still held, the next item
//   completes its rounds and then waits in the engine until the output frees.
module simon_128_128_block_cipher_top
	import simon_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_wdata
);

	localparam int LAST = ROUND_COUNT - 1;

	logic [KEY_W-1:0] key_first_q;
	logic [KEY_W-1:0] key_second_q;
	logic             restart_q;    // expansion pending, set at reset too
	logic             fill_busy;
	logic [KEY_W-1:0] push;
	ring_ctl_t        rot;
	ring_ctl_t        ctl;
	logic [KEY_W-1:0] ring [ROUND_COUNT];
	logic [KEY_W-1:0] round_key;
	logic             key_hit;

	// key registers
	assign key_hit = cfg_we && ((cfg_index == CFG_KEY_FIRST) || (cfg_index == CFG_KEY_SECOND));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q  <= '0;
			key_second_q <= '0;
			restart_q    <= 1'b1;
		end else begin
			restart_q <= key_hit;
			if (cfg_we && (cfg_index == CFG_KEY_FIRST)) begin
				key_first_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_index == CFG_KEY_SECOND)) begin
				key_second_q <= cfg_wdata;
			end
		end
	end

	simon_kgen #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_kgen (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (restart_q),
		.key_first  (key_first_q),
		.key_second (key_second_q),
		.busy       (fill_busy),
		.push       (push)
	);

	// ring control: items wait out fill; a key write mid-item overlaps fill and rotation
	always_comb begin
		ctl.fill = fill_busy;
		ctl.fwd  = rot.fwd;
		ctl.bwd  = rot.bwd;
	end

	// round key ring: cell 0 is the head for encryption, the last cell for decryption
	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_ring
		localparam int NXT = (i + 1) % ROUND_COUNT;
		localparam int PRV = (i + ROUND_COUNT - 1) % ROUND_COUNT;
		logic [KEY_W-1:0] fwd_in;

		if (i == LAST) begin : g_tail
			assign fwd_in = ctl.fill ? push : ring[NXT];
		end else begin : g_body
			assign fwd_in = ring[NXT];
		end

		simon_kcell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.fwd_in (fwd_in),
			.bwd_in (ring[PRV]),
			.key    (ring[i])
		);
	end

	assign round_key = rot.bwd ? ring[LAST] : ring[0];

	simon_engine #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.key_busy  (restart_q || fill_busy),
		.round_key (round_key),
		.rot       (rot)
	);

endmodule

FILE: rtl/simon_kcell.sv
// One cell of the round key ring: holds a single round key.
module simon_kcell
	import simon_pkg::*;
(
	input  logic             clk,
	input  ring_ctl_t        ctl,
	input  logic [KEY_W-1:0] fwd_in,
	input  logic [KEY_W-1:0] bwd_in,
	output logic [KEY_W-1:0] key
);

	logic [KEY_W-1:0] key_q;

	always_ff @(posedge clk) begin
		if (ctl.fill || ctl.fwd) begin
			key_q <= fwd_in;
		end else if (ctl.bwd) begin
			key_q <= bwd_in;
		end
	end

	assign key = key_q;

endmodule

FILE: rtl/simon_kgen.sv
// Key schedule generator: produces one round key per cycle into the ring tail.
module simon_kgen
	import simon_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key_first,
	input  logic [KEY_W-1:0] key_second,
	output logic             busy,
	output logic [KEY_W-1:0] push
);

	localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int ZJ_W  = $clog2(Z2_LEN);
	localparam logic [ZJ_W-1:0] ZJ_TOP = ZJ_W'(Z2_LEN - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ZJ_W-1:0]  zj_q;
	logic [KEY_W-1:0] a_q;   // k[i-2]
	logic [KEY_W-1:0] b_q;   // k[i-1]
	logic [KEY_W-1:0] t3;
	logic [KEY_W-1:0] tmix;
	logic [KEY_W-1:0] nxt;
	logic             zbit;

	always_comb begin
		t3   = {b_q[2:0], b_q[KEY_W-1:3]};
		tmix = t3 ^ {t3[0], t3[KEY_W-1:1]};
		zbit = Z2_SEQ[ZJ_TOP - zj_q];
		nxt  = a_q ^ tmix ^ {{(KEY_W-1){1'b0}}, zbit} ^ ROUND_CONST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			zj_q   <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			zj_q   <= '0;
			a_q    <= key_second;
			b_q    <= key_first;
		end else if (busy_q) begin
			a_q   <= b_q;
			b_q   <= nxt;
			zj_q  <= (zj_q == ZJ_TOP) ? '0 : zj_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROUND_COUNT - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign push = a_q;

endmodule

FILE: rtl/simon_engine.sv
// Feistel round engine with input control and output register.
module simon_engine
	import simon_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             key_busy,
	input  logic [KEY_W-1:0] round_key,
	output ring_ctl_t        rot
);

	localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t           st_q;
	logic             dec_q;
	logic [CNT_W-1:0] rnd_q;
	logic [KEY_W-1:0] left_q;
	logic [KEY_W-1:0] right_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [KEY_W-1:0] left_nxt;
	logic             out_free;
	logic             take;

	always_comb begin
		left_nxt = right_q
			^ ({left_q[KEY_W-2:0], left_q[KEY_W-1]} & {left_q[KEY_W-9:0], left_q[KEY_W-1:KEY_W-8]})
			^ {left_q[KEY_W-3:0], left_q[KEY_W-1:KEY_W-2]}
			^ round_key;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (st_q != ST_IDLE) || key_busy;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			dec_q       <= OP_ENC;
			rnd_q       <= '0;
			left_q      <= '0;
			right_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (take) begin
						dec_q <= in_data.req_type;
						rnd_q <= '0;
						st_q  <= ST_RUN;
						if (in_data.req_type == OP_DEC) begin
							left_q  <= in_data.block_word_second;
							right_q <= in_data.block_word_first;
						end else begin
							left_q  <= in_data.block_word_first;
							right_q <= in_data.block_word_second;
						end
					end
				end
				ST_RUN: begin
					left_q  <= left_nxt;
					right_q <= left_q;
					rnd_q   <= rnd_q + 1'b1;
					if (rnd_q == CNT_W'(ROUND_COUNT - 1)) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							st_q        <= ST_IDLE;
							if (dec_q == OP_DEC) begin
								out_q <= '{result_word_first: left_q,
									result_word_second: left_nxt};
							end else begin
								out_q <= '{result_word_first: left_nxt,
									result_word_second: left_q};
							end
						end else begin
							st_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
						if (dec_q == OP_DEC) begin
							out_q <= '{result_word_first: right_q,
								result_word_second: left_q};
						end else begin
							out_q <= '{result_word_first: left_q,
								result_word_second: right_q};
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rot.fill = 1'b0;
		rot.fwd  = (st_q == ST_RUN) && (dec_q == OP_ENC);
		rot.bwd  = (st_q == ST_RUN) && (dec_q == OP_DEC);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: tb/sv/simon_128_128_block_cipher_top_tb.sv
// Testbench for the Simon 128/128 block cipher top: directed table, then random blocks.
module simon_128_128_block_cipher_top_tb;
	import simon_pkg::*;

	localparam int N_ROUNDS    = ROUND_COUNT_DEF;
	localparam int HOLD_CYCLES = 600;       // long receiver hold, well over two items' worth
	localparam int PHASE_ITEMS = 310;       // random blocks per idling phase
	localparam int HOLD_AT     = 40;        // random block after which the long hold starts
	localparam int TIMEOUT     = 4_000_000; // time units, several times the slowest pass

	// register indexes past the end of the key list; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

	typedef enum logic {ROW_BLOCK, ROW_KEY} row_kind_t;

	// one line of the directed plan: either a block transfer or a key register write
	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [KEY_W-1:0]       wdata;
		in_item_t               item;
		logic                   typed;
		out_item_t              want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0]     cfg_wdata;

	// sideband travelling with in_data: a result typed into the plan overrides the predictor
	logic                 vector_check;
	out_item_t            vector_result;

	// predictor state: key registers and the expanded round key list
	logic [KEY_W-1:0]     cipher_key_first;
	logic [KEY_W-1:0]     cipher_key_second;
	logic [KEY_W-1:0]     sched_keys [N_ROUNDS];

	out_item_t            blocks_due [$];
	int unsigned          blocks_offered  = 0;
	int unsigned          blocks_returned = 0;
	int unsigned          mismatch_count  = 0;

	int unsigned          send_idle_pct = 14;
	int unsigned          recv_idle_pct = 48;
	logic                 hold_go   = 1'b0;
	logic                 long_hold = 1'b0;

	plan_row_t            plan [$];

	simon_128_128_block_cipher_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [KEY_W-1:0] rotl64(logic [KEY_W-1:0] v, int n);
		return (v << n) | (v >> (KEY_W - n));
	endfunction

	// Key schedule for two key words: right rotations by 3 and 1 are done as
	// left rotations by 61 and 63. One z2 bit per round key from index two on.
	function automatic void expand_key_sched();
		logic [KEY_W-1:0] t;
		int               j;
		sched_keys[0] = cipher_key_second;
		sched_keys[1] = cipher_key_first;
		for (int i = 2; i < N_ROUNDS; i++) begin
			t = rotl64(sched_keys[i-1], 61);
			t = t ^ rotl64(t, 63);
			j = (i - 2) % Z2_LEN;
			sched_keys[i] = sched_keys[i-2] ^ t ^ {{(KEY_W-1){1'b0}}, Z2_SEQ[Z2_LEN-1-j]}
				^ ROUND_CONST;
		end
	endfunction

	function automatic void apply_key_write(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
		case (idx)
			CFG_KEY_FIRST: begin
				cipher_key_first = val;
				expand_key_sched();
			end
			CFG_KEY_SECOND: begin
				cipher_key_second = val;
				expand_key_sched();
			end
			default: ;
		endcase
	endfunction

	// Feistel network; decryption runs on swapped words with the keys reversed,
	// then swaps back so that it undoes encryption word for word.
	function automatic out_item_t simon_transform(in_item_t it);
		logic [KEY_W-1:0] lw;
		logic [KEY_W-1:0] rw;
		logic [KEY_W-1:0] x;
		logic             dec;
		out_item_t        res;
		dec = (it.req_type == OP_DEC);
		lw  = dec ? it.block_word_second : it.block_word_first;
		rw  = dec ? it.block_word_first  : it.block_word_second;
		for (int i = 0; i < N_ROUNDS; i++) begin
			x  = lw;
			lw = rw ^ (rotl64(x, 1) & rotl64(x, 8)) ^ rotl64(x, 2)
				^ sched_keys[dec ? N_ROUNDS - 1 - i : i];
			rw = x;
		end
		res.result_word_first  = dec ? rw : lw;
		res.result_word_second = dec ? lw : rw;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: key writes, input transfers and output transfers, all
	// sampled on the rising edge so values are those from before the edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_we)
				apply_key_write(cfg_index, cfg_wdata);
			if (in_valid && !in_stall)
				blocks_due.push_back(vector_check ? vector_result : simon_transform(in_data));
			if (out_valid && !out_stall) begin
				blocks_returned++;
				if (blocks_due.size() == 0) begin
					$error("result transfer with nothing outstanding: %h %h",
						out_data.result_word_first, out_data.result_word_second);
					mismatch_count++;
				end else begin
					want = blocks_due.pop_front();
					if (out_data.result_word_first !== want.result_word_first) begin
						$error("result_word_first: expected %h, actual %h",
							want.result_word_first, out_data.result_word_first);
						mismatch_count++;
					end
					if (out_data.result_word_second !== want.result_word_second) begin
						$error("result_word_second: expected %h, actual %h",
							want.result_word_second, out_data.result_word_second);
						mismatch_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall at the phase rate, forced high during the long hold
	// ------------------------------------------------------------------
	always @(posedge clk)
		out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);

	// Long hold counted here, so the engine fills up and stalls its input
	// while the sender keeps offering blocks.
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------

	// Offer one block; random idle cycles first. Returns at the edge of the transfer.
	task automatic offer_block(in_item_t it, logic typed, out_item_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		in_data       <= it;
		vector_check  <= typed;
		vector_result <= want;
		do @(posedge clk); while (in_stall);
		blocks_offered++;
	endtask

	// Wait for every outstanding result, then for a round pass more so that any
	// key expansion still running has finished, then pulse one register write.
	task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
		in_valid <= 1'b0;
		while (blocks_returned != blocks_offered) @(posedge clk);
		repeat (N_ROUNDS + 4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Block word mostly random, sometimes an extreme or a single set/clear bit
	function automatic logic [KEY_W-1:0] pick_word();
		logic [KEY_W-1:0] one_hot;
		one_hot = {{(KEY_W-1){1'b0}}, 1'b1} << $urandom_range(KEY_W - 1);
		case ($urandom_range(15))
			0:       return '0;
			1:       return ALL_ONES;
			2:       return one_hot;
			3:       return ~one_hot;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Random blocks; about one in four feeds the previous result back through
	// the opposite operation, which must give back the previous block.
	task automatic run_random(int unsigned count, logic with_hold);
		in_item_t  it;
		in_item_t  prev;
		out_item_t prev_res;
		logic      have_prev;
		have_prev = 1'b0;
		for (int unsigned n = 0; n < count; n++) begin
			if (have_prev && $urandom_range(3) == 0) begin
				it.req_type          = (prev.req_type == OP_DEC) ? OP_ENC : OP_DEC;
				it.block_word_first  = prev_res.result_word_first;
				it.block_word_second = prev_res.result_word_second;
			end else begin
				it.req_type          = ($urandom_range(1) != 0) ? OP_DEC : OP_ENC;
				it.block_word_first  = pick_word();
				it.block_word_second = pick_word();
			end
			if (with_hold && n == HOLD_AT)
				hold_go <= 1'b1;
			offer_block(it, 1'b0, '0);
			prev      = it;
			prev_res  = simon_transform(it);
			have_prev = 1'b1;
		end
	endtask

	function automatic plan_row_t row_block(logic op, logic [KEY_W-1:0] w1, logic [KEY_W-1:0] w2);
		plan_row_t r;
		r.kind  = ROW_BLOCK;
		r.idx   = CFG_KEY_FIRST;
		r.wdata = '0;
		r.item  = '{req_type: op, block_word_first: w1, block_word_second: w2};
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic plan_row_t row_vector(logic op, logic [KEY_W-1:0] w1,
		logic [KEY_W-1:0] w2, logic [KEY_W-1:0] e1, logic [KEY_W-1:0] e2);
		plan_row_t r;
		r       = row_block(op, w1, w2);
		r.typed = 1'b1;
		r.want  = '{result_word_first: e1, result_word_second: e2};
		return r;
	endfunction

	function automatic plan_row_t row_key(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
		plan_row_t r;
		r       = row_block(OP_ENC, '0, '0);
		r.kind  = ROW_KEY;
		r.idx   = idx;
		r.wdata = val;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		in_valid      <= 1'b0;
		in_data       <= '0;
		vector_check  <= 1'b0;
		vector_result <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_KEY_FIRST;
		cfg_wdata     <= '0;

		// reset state: zero key, expanded
		cipher_key_first  = '0;
		cipher_key_second = '0;
		expand_key_sched();

		plan = '{
			// zero key straight after reset: extremes and patterns, both operations
			row_block(OP_ENC, '0, '0),
			row_block(OP_ENC, ALL_ONES, ALL_ONES),
			row_block(OP_DEC, '0, '0),
			row_block(OP_DEC, ALL_ONES, ALL_ONES),
			row_block(OP_ENC, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555),
			row_block(OP_DEC, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA),
			row_block(OP_ENC, 64'h0000_0000_0000_0001, '0),
			row_block(OP_ENC, '0, 64'h8000_0000_0000_0000),
			row_block(OP_DEC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001),
			// writes past the key list must leave the key untouched
			row_key(CFG_SPARE_LO, 64'h0123_4567_89AB_CDEF),
			row_key(CFG_SPARE_HI, 64'hFEDC_BA98_7654_3210),
			row_block(OP_ENC, '0, '0),
			// published Simon 128/128 vector, and its decryption back to plaintext
			row_key(CFG_KEY_FIRST,  64'h0F0E_0D0C_0B0A_0908),
			row_key(CFG_KEY_SECOND, 64'h0706_0504_0302_0100),
			row_vector(OP_ENC, 64'h6373_6564_2073_7265, 64'h6C6C_6576_6172_7420,
				64'h4968_1B1E_1E54_FE3F, 64'h65AA_832A_F84E_0BBC),
			row_vector(OP_DEC, 64'h4968_1B1E_1E54_FE3F, 64'h65AA_832A_F84E_0BBC,
				64'h6373_6564_2073_7265, 64'h6C6C_6576_6172_7420),
			// all-ones key
			row_key(CFG_KEY_FIRST,  ALL_ONES),
			row_key(CFG_KEY_SECOND, ALL_ONES),
			row_block(OP_ENC, ALL_ONES, ALL_ONES),
			row_block(OP_DEC, '0, '0),
			row_block(OP_ENC, '0, ALL_ONES)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, under the first idling mix
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_KEY)
				write_key(plan[r].idx, plan[r].wdata);
			else
				offer_block(plan[r].item, plan[r].typed, plan[r].want);
		end

		// phase one: sender idles lightly, receiver heavily; zero key
		write_key(CFG_KEY_FIRST,  '0);
		write_key(CFG_KEY_SECOND, '0);
		run_random(PHASE_ITEMS, 1'b0);

		// phase two: roles swapped, random key, long receiver hold part way in
		write_key(CFG_KEY_FIRST,  {$urandom(), $urandom()});
		write_key(CFG_KEY_SECOND, {$urandom(), $urandom()});
		send_idle_pct = 48;
		recv_idle_pct <= 14;
		run_random(PHASE_ITEMS, 1'b1);

		// phase three: no idling on either side, random first key word, zero second
		write_key(CFG_SPARE_HI,   {$urandom(), $urandom()});
		write_key(CFG_KEY_FIRST,  {$urandom(), $urandom()});
		write_key(CFG_KEY_SECOND, '0);
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		run_random(PHASE_ITEMS, 1'b0);

		// drain, then allow a round pass for anything stray
		in_valid <= 1'b0;
		while (blocks_returned != blocks_offered) @(posedge clk);
		repeat (N_ROUNDS + 8) @(posedge clk);
		if (blocks_due.size() != 0) begin
			$error("%0d result(s) never arrived", blocks_due.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("simon_128_128_block_cipher_top_tb: PASS");
		else
			$display("simon_128_128_block_cipher_top_tb: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT);
		$display("simon_128_128_block_cipher_top_tb: FAIL");
		$finish;
	end

endmodule
